/* hw/rtl/tars_pkg.sv */
package tars_pkg;

  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF    = 16;

  // item field widths
  localparam int SLOT_W  = 12;
  localparam int COORD_W = 32;
  localparam int VTX_W   = 3 * COORD_W;
  localparam int RATIO_W = 32;
  localparam int SUM_W   = 64;
  localparam int CNT_W   = 32;

  // datapath widths
  localparam int EDGE_W    = COORD_W + 1;
  localparam int RAD_W     = 2 * EDGE_W;
  localparam int TERM_W    = EDGE_W + 1;
  localparam int MUL_DIG_W = 8;
  localparam int MUL_A_W   = 2 * TERM_W;
  localparam int MUL_B_W   = ((TERM_W + MUL_DIG_W - 1) / MUL_DIG_W) * MUL_DIG_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int NUM_W     = 3 * EDGE_W;
  localparam int DEN_W     = 3 * TERM_W;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [SLOT_W-1:0]         vertex_slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [SLOT_W-1:0]         corner_a;
    logic [SLOT_W-1:0]         corner_b;
    logic [SLOT_W-1:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0] aspect_ratio;
    logic               degenerate;
    logic [RATIO_W-1:0] min_ratio;
    logic [RATIO_W-1:0] max_ratio;
    logic [SUM_W-1:0]   ratio_sum;
    logic [CNT_W-1:0]   triangle_count;
  } out_item_t;

endpackage

/* hw/rtl/tars_in_if.sv */
interface tars_in_if;
  import tars_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/tars_out_if.sv */
interface tars_out_if;
  import tars_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/tars_vstore.sv */
module tars_vstore #(
  parameter int DEPTH = tars_pkg::VERTEX_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tars_pkg::VTX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [tars_pkg::VTX_W-1:0] rd_data_r
);
  import tars_pkg::*;

  logic [VTX_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/tars_mul.sv */
module tars_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tars_pkg::MUL_A_W-1:0]  op_a,
  input  logic [tars_pkg::MUL_B_W-1:0]  op_b,
  output logic                          done,
  output logic [tars_pkg::MUL_P_W-1:0]  prod
);
  import tars_pkg::*;

  localparam int STEPS = MUL_B_W / MUL_DIG_W;
  localparam int CW    = $clog2(STEPS + 1);

  logic [MUL_P_W-1:0]   acc_r;
  logic [MUL_P_W-1:0]   a_sh_r;
  logic [MUL_B_W-1:0]   b_r;
  logic [CW-1:0]        cnt_r;
  logic                 done_r;
  logic [MUL_DIG_W-1:0] dig;
  logic [MUL_P_W-1:0]   part;

  // one digit of b per cycle
  assign dig  = b_r[MUL_DIG_W-1:0];
  assign part = a_sh_r * MUL_P_W'(dig);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      a_sh_r <= MUL_P_W'(op_a);
      b_r    <= op_b;
    end else if (cnt_r != '0) begin
      acc_r  <= acc_r + part;
      a_sh_r <= a_sh_r << MUL_DIG_W;
      b_r    <= b_r >> MUL_DIG_W;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* hw/rtl/tars_root.sv */
module tars_root (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tars_pkg::RAD_W-1:0]  rad,
  output logic                        done,
  output logic [tars_pkg::EDGE_W-1:0] root
);
  import tars_pkg::*;

  localparam int CW    = $clog2(EDGE_W + 1);
  localparam int REM_W = EDGE_W + 3;

  logic [RAD_W-1:0]  rad_r;
  logic [EDGE_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_t;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic [CW-1:0]     cnt_r;
  logic              done_r;

  // digit-by-digit square root, one result bit per cycle
  assign rem_t = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(EDGE_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      root_r <= '0;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= ge ? (rem_t - trial) : rem_t;
      root_r <= {root_r[EDGE_W-2:0], ge};
      rad_r  <= rad_r << 2;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* hw/rtl/tars_div.sv */
module tars_div #(
  parameter int FRAC_BITS = tars_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tars_pkg::NUM_W-1:0]   num,
  input  logic [tars_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [tars_pkg::RATIO_W-1:0] quot
);
  import tars_pkg::*;

  localparam int SN_W  = NUM_W + FRAC_BITS;
  localparam int DS_W  = DEN_W + RATIO_W - 1;
  localparam int CMP_W = ((SN_W > DS_W) ? SN_W : DS_W) + 1;
  localparam int CW    = $clog2(RATIO_W + 1);

  logic [SN_W-1:0]    sn;
  logic [SN_W-1:0]    rem_r;
  logic [DS_W-1:0]    dsh_r;
  logic [RATIO_W-1:0] q_r;
  logic               sat;
  logic               sat_r;
  logic               ge;
  logic [CW-1:0]      cnt_r;
  logic               done_r;

  // scaled numerator, overflow test against den * 2^32
  assign sn  = SN_W'(num) << FRAC_BITS;
  assign sat = CMP_W'(sn) >= (CMP_W'(den) << RATIO_W);
  assign ge  = CMP_W'(dsh_r) <= CMP_W'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(RATIO_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= sn;
      dsh_r <= DS_W'(den) << (RATIO_W - 1);
      sat_r <= sat;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= rem_r - SN_W'(dsh_r);
      end
      q_r   <= {q_r[RATIO_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = sat_r ? '1 : q_r;

endmodule

/* hw/rtl/triangle_aspect_ratio_stats.sv */
// Write-vertex and clear beats are taken in the idle state and leave the block ready.
// A triangle beat runs three corner reads from the vertex memory port, nine squares and
// four products on one 8-bit-per-cycle multiplier, three 33-bit square roots and one
// divider with a 32-bit quotient; a degenerate triangle skips the products and divider.
// One triangle is in flight at a time; its result sits in an output register.
// Synchronous active-low reset clears control and statistics; vertex memory is not cleared.
module triangle_aspect_ratio_stats #(
  parameter int VERTEX_DEPTH = tars_pkg::VERTEX_DEPTH_DEF,
  parameter int FRAC_BITS    = tars_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tars_in_if.sink    in_ch,
  tars_out_if.source out_ch
);
  import tars_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE = 14'h0001,
    S_RD_B = 14'h0002,
    S_RD_C = 14'h0004,
    S_RD_L = 14'h0008,
    S_SQ   = 14'h0010,
    S_SQW  = 14'h0020,
    S_RT   = 14'h0040,
    S_RTW  = 14'h0080,
    S_TERM = 14'h0100,
    S_MU   = 14'h0200,
    S_MUW  = 14'h0400,
    S_DV   = 14'h0800,
    S_DVW  = 14'h1000,
    S_FIN  = 14'h2000
  } state_t;

  state_t state_r, state_nxt;

  logic in_fire;
  cmd_t in_cmd;
  logic fin_go;

  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [VTX_W-1:0] mem_wdata;
  logic [VTX_W-1:0] mem_rdata;

  logic [SLOT_W-1:0] crn_b_r, crn_c_r;
  logic [2:0]        ok_r;
  logic [VTX_W-1:0]  va_r, vb_r, vc_r;
  logic [1:0]        edge_idx_r;
  logic [1:0]        axis_r;
  logic [1:0]        mstep_r;
  logic [RAD_W-1:0]  sq_acc_r;
  logic [EDGE_W-1:0] edge_r [3];
  logic [TERM_W-1:0] tu_r, tv_r, tw_r;
  logic [MUL_A_W-1:0] t_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [RATIO_W-1:0] ratio_r;
  logic              degen_r;

  logic [VTX_W-1:0]          p_vtx, q_vtx;
  logic signed [COORD_W-1:0] p_c, q_c;
  logic signed [COORD_W:0]   diff;
  logic [EDGE_W-1:0]         mag;
  logic signed [TERM_W:0]    su, sv, sw;
  logic                      degen;

  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               root_start, root_done;
  logic [EDGE_W-1:0]  root_q;
  logic               div_start, div_done;
  logic [RATIO_W-1:0] div_q;

  logic [RATIO_W-1:0] min_r, max_r, min_nxt, max_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W:0]     sum_ext;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    return 32'(s) < 32'(VERTEX_DEPTH);
  endfunction

  // handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_cmd      = cmd_t'(in_ch.data.cmd);
  assign fin_go      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // vertex memory ports
  assign mem_we    = in_fire && (in_cmd == CMD_WRITE) && slot_ok(in_ch.data.vertex_slot);
  assign mem_waddr = AW'(in_ch.data.vertex_slot);
  assign mem_wdata = {in_ch.data.pos_z, in_ch.data.pos_y, in_ch.data.pos_x};

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = AW'(in_ch.data.corner_a);
    unique case (state_r)
      S_IDLE: begin
        mem_re = in_fire && (in_cmd == CMD_TRI) && slot_ok(in_ch.data.corner_a);
      end
      S_RD_B: begin
        mem_re    = ok_r[1];
        mem_raddr = AW'(crn_b_r);
      end
      S_RD_C: begin
        mem_re    = ok_r[2];
        mem_raddr = AW'(crn_c_r);
      end
      default: ;
    endcase
  end

  tars_vstore #(
    .DEPTH (VERTEX_DEPTH),
    .AW    (AW)
  ) u_vstore (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  // edge endpoints and coordinate difference
  always_comb begin
    case (edge_idx_r)
      2'd0: begin
        p_vtx = va_r;
        q_vtx = vb_r;
      end
      2'd1: begin
        p_vtx = vb_r;
        q_vtx = vc_r;
      end
      default: begin
        p_vtx = vc_r;
        q_vtx = va_r;
      end
    endcase
  end

  assign p_c  = p_vtx[axis_r*COORD_W +: COORD_W];
  assign q_c  = q_vtx[axis_r*COORD_W +: COORD_W];
  assign diff = {p_c[COORD_W-1], p_c} - {q_c[COORD_W-1], q_c};
  assign mag  = diff[COORD_W] ? EDGE_W'(-diff) : EDGE_W'(diff);

  // denominator terms
  assign su = $signed({2'b00, edge_r[1]}) + $signed({2'b00, edge_r[2]})
            - $signed({2'b00, edge_r[0]});
  assign sv = $signed({2'b00, edge_r[2]}) + $signed({2'b00, edge_r[0]})
            - $signed({2'b00, edge_r[1]});
  assign sw = $signed({2'b00, edge_r[0]}) + $signed({2'b00, edge_r[1]})
            - $signed({2'b00, edge_r[2]});
  assign degen = su[TERM_W] || (su == '0) || sv[TERM_W] || (sv == '0)
              || sw[TERM_W] || (sw == '0);

  // shared multiplier operands
  always_comb begin
    mul_a = MUL_A_W'(mag);
    mul_b = MUL_B_W'(mag);
    if (state_r == S_MU) begin
      case (mstep_r)
        2'd0: begin
          mul_a = MUL_A_W'(edge_r[0]);
          mul_b = MUL_B_W'(edge_r[1]);
        end
        2'd1: begin
          mul_a = t_r;
          mul_b = MUL_B_W'(edge_r[2]);
        end
        2'd2: begin
          mul_a = MUL_A_W'(tu_r);
          mul_b = MUL_B_W'(tv_r);
        end
        default: begin
          mul_a = t_r;
          mul_b = MUL_B_W'(tw_r);
        end
      endcase
    end
  end

  assign mul_start  = (state_r == S_SQ) || (state_r == S_MU);
  assign root_start = (state_r == S_RT);
  assign div_start  = (state_r == S_DV);

  tars_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tars_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .rad   (sq_acc_r),
    .done  (root_done),
    .root  (root_q)
  );

  tars_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire && (in_cmd == CMD_TRI)) state_nxt = S_RD_B;
      S_RD_B: state_nxt = S_RD_C;
      S_RD_C: state_nxt = S_RD_L;
      S_RD_L: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SQW;
      S_SQW:  if (mul_done) state_nxt = (axis_r == 2'd2) ? S_RT : S_SQ;
      S_RT:   state_nxt = S_RTW;
      S_RTW:  if (root_done) state_nxt = (edge_idx_r == 2'd2) ? S_TERM : S_SQ;
      S_TERM: state_nxt = degen ? S_FIN : S_MU;
      S_MU:   state_nxt = S_MUW;
      S_MUW:  if (mul_done) state_nxt = (mstep_r == 2'd3) ? S_DV : S_MU;
      S_DV:   state_nxt = S_DVW;
      S_DVW:  if (div_done) state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      crn_b_r <= in_ch.data.corner_b;
      crn_c_r <= in_ch.data.corner_c;
      ok_r    <= {slot_ok(in_ch.data.corner_c), slot_ok(in_ch.data.corner_b),
                  slot_ok(in_ch.data.corner_a)};
    end
    unique case (state_r)
      S_RD_B: va_r <= ok_r[0] ? mem_rdata : '0;
      S_RD_C: vb_r <= ok_r[1] ? mem_rdata : '0;
      S_RD_L: begin
        vc_r       <= ok_r[2] ? mem_rdata : '0;
        edge_idx_r <= '0;
        axis_r     <= '0;
        sq_acc_r   <= '0;
      end
      S_SQW: if (mul_done) begin
        sq_acc_r <= sq_acc_r + mul_prod[RAD_W-1:0];
        axis_r   <= axis_r + 1'b1;
      end
      S_RTW: if (root_done) begin
        edge_r[edge_idx_r] <= root_q;
        edge_idx_r         <= edge_idx_r + 1'b1;
        axis_r             <= '0;
        sq_acc_r           <= '0;
      end
      S_TERM: begin
        tu_r    <= su[TERM_W-1:0];
        tv_r    <= sv[TERM_W-1:0];
        tw_r    <= sw[TERM_W-1:0];
        mstep_r <= '0;
        degen_r <= degen;
        ratio_r <= '1;
      end
      S_MUW: if (mul_done) begin
        case (mstep_r)
          2'd0:    t_r   <= mul_prod[MUL_A_W-1:0];
          2'd1:    num_r <= mul_prod[NUM_W-1:0];
          2'd2:    t_r   <= mul_prod[MUL_A_W-1:0];
          default: den_r <= mul_prod[DEN_W-1:0];
        endcase
        mstep_r <= mstep_r + 1'b1;
      end
      S_DVW: if (div_done) ratio_r <= div_q;
      S_FIN: if (fin_go) begin
        out_data_r.aspect_ratio   <= ratio_r;
        out_data_r.degenerate     <= degen_r;
        out_data_r.min_ratio      <= min_nxt;
        out_data_r.max_ratio      <= max_nxt;
        out_data_r.ratio_sum      <= sum_nxt;
        out_data_r.triangle_count <= cnt_nxt;
      end
      default: ;
    endcase
  end

  // statistics update
  assign min_nxt = (ratio_r < min_r) ? ratio_r : min_r;
  assign max_nxt = (ratio_r > max_r) ? ratio_r : max_r;
  assign sum_ext = {1'b0, sum_r} + (SUM_W+1)'(ratio_r);
  assign sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= '1;
      max_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
        sum_r       <= sum_nxt;
        cnt_r       <= cnt_nxt;
      end else begin
        if (out_ch.ready) begin
          out_valid_r <= 1'b0;
        end
        if (in_fire && (in_cmd == CMD_CLEAR)) begin
          min_r <= '1;
          max_r <= '0;
          sum_r <= '0;
          cnt_r <= '0;
        end
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef SYNTHESIS
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.min_ratio <= out_data_r.max_ratio)
    else $error("result min above max");
  a_count_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.triangle_count != '0)
    else $error("result with zero count");
  a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.degenerate) |-> out_data_r.aspect_ratio == '1)
    else $error("degenerate result not saturated");
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished triangle not loaded");
`endif

endmodule

/* bench/triangle_aspect_ratio_stats_tb.sv */
`timescale 1ns / 100ps

module triangle_aspect_ratio_stats_tb;
  import tars_pkg::*;

  localparam int          DEPTH       = VERTEX_DEPTH_DEF;
  localparam int          FRAC        = FRAC_BITS_DEF;
  localparam int          MAX_WAIT    = 18;
  localparam int          DRAIN_WAIT  = 400;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic clk;
  logic rst_n;

  tars_in_if  in_ch ();
  tars_out_if out_ch ();

  triangle_aspect_ratio_stats dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // vertex store mirror and running statistics
  logic [COORD_W-1:0] mesh_x [DEPTH];
  logic [COORD_W-1:0] mesh_y [DEPTH];
  logic [COORD_W-1:0] mesh_z [DEPTH];
  bit                 slot_written [DEPTH];
  int                 written_slots [$];
  logic [RATIO_W-1:0] stat_min;
  logic [RATIO_W-1:0] stat_max;
  logic [SUM_W-1:0]   stat_sum;
  logic [CNT_W-1:0]   stat_count;

  out_item_t pending_ratios [$];
  int        error_count;
  int        beats_sent;
  int        triangles_checked;
  int        degenerate_seen;
  int        saturated_seen;
  int        cycle_count;
  bit        no_idle;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("triangle_aspect_ratio_stats_tb: errors");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h (t=%0t)", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [34:0] edge_length(input int i, input int j);
    logic signed [33:0] d;
    logic [33:0]        ad;
    logic [127:0]       sq;
    logic [63:0]        r;
    logic [63:0]        c;
    sq = '0;
    for (int ax = 0; ax < 3; ax++) begin
      case (ax)
        0: d = {{2{mesh_x[i][31]}}, mesh_x[i]} - {{2{mesh_x[j][31]}}, mesh_x[j]};
        1: d = {{2{mesh_y[i][31]}}, mesh_y[i]} - {{2{mesh_y[j][31]}}, mesh_y[j]};
        default: d = {{2{mesh_z[i][31]}}, mesh_z[i]} - {{2{mesh_z[j][31]}}, mesh_z[j]};
      endcase
      ad = (d < 0) ? -d : d;
      sq = sq + 128'(ad) * 128'(ad);
    end
    r = '0;
    for (int bit_i = 34; bit_i >= 0; bit_i--) begin
      c = r | (64'd1 << bit_i);
      if (128'(c) * 128'(c) <= sq) r = c;
    end
    return r[34:0];
  endfunction

  // ratio of one triangle plus the statistics after counting it
  function automatic out_item_t measure_triangle(input int ca, input int cb, input int cc);
    out_item_t          res;
    logic [34:0]        ea, eb, ec;
    logic signed [35:0] u, v, w;
    logic [159:0]       num, den, quo;
    logic [RATIO_W-1:0] ratio;
    logic               degen;
    ea = edge_length(ca, cb);
    eb = edge_length(cb, cc);
    ec = edge_length(cc, ca);
    u = $signed({1'b0, eb}) + $signed({1'b0, ec}) - $signed({1'b0, ea});
    v = $signed({1'b0, ec}) + $signed({1'b0, ea}) - $signed({1'b0, eb});
    w = $signed({1'b0, ea}) + $signed({1'b0, eb}) - $signed({1'b0, ec});
    degen = 1'b0;
    if (u <= 0 || v <= 0 || w <= 0) begin
      degen = 1'b1;
      ratio = '1;
    end else begin
      den = 160'(u) * 160'(v) * 160'(w);
      num = (160'(ea) * 160'(eb) * 160'(ec)) << FRAC;
      quo = num / den;
      ratio = (quo > 160'hFFFF_FFFF) ? '1 : quo[31:0];
    end
    if (ratio < stat_min) stat_min = ratio;
    if (ratio > stat_max) stat_max = ratio;
    if (stat_sum > ~64'd0 - 64'(ratio)) stat_sum = '1;
    else stat_sum = stat_sum + 64'(ratio);
    if (stat_count != '1) stat_count = stat_count + 1;
    res.aspect_ratio   = ratio;
    res.degenerate     = degen;
    res.min_ratio      = stat_min;
    res.max_ratio      = stat_max;
    res.ratio_sum      = stat_sum;
    res.triangle_count = stat_count;
    return res;
  endfunction

  // update the mirror for one accepted beat
  task automatic predict_beat(input in_item_t it);
    case (it.cmd)
      CMD_WRITE: begin
        mesh_x[it.vertex_slot] = it.pos_x;
        mesh_y[it.vertex_slot] = it.pos_y;
        mesh_z[it.vertex_slot] = it.pos_z;
        if (!slot_written[it.vertex_slot]) begin
          slot_written[it.vertex_slot] = 1'b1;
          written_slots = {written_slots, int'(it.vertex_slot)};
        end
      end
      CMD_TRI: begin
        pending_ratios = {pending_ratios,
                          measure_triangle(it.corner_a, it.corner_b, it.corner_c)};
      end
      CMD_CLEAR: begin
        stat_min   = '1;
        stat_max   = '0;
        stat_sum   = '0;
        stat_count = '0;
      end
      default: ;
    endcase
  endtask

  // send one beat after a random gap; valid stays high when the gap is zero
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_beat(it);
    beats_sent++;
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd         = 2'($urandom);
    it.vertex_slot = SLOT_W'($urandom);
    it.pos_x       = $urandom;
    it.pos_y       = $urandom;
    it.pos_z       = $urandom;
    it.corner_a    = SLOT_W'($urandom);
    it.corner_b    = SLOT_W'($urandom);
    it.corner_c    = SLOT_W'($urandom);
    return it;
  endfunction

  task automatic write_vertex(input int slot, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
    in_item_t it;
    it = noise_item();
    it.cmd         = CMD_WRITE;
    it.vertex_slot = SLOT_W'(slot);
    it.pos_x       = x;
    it.pos_y       = y;
    it.pos_z       = z;
    send_item(it);
  endtask

  task automatic send_triangle(input int ca, input int cb, input int cc);
    in_item_t it;
    it = noise_item();
    it.cmd      = CMD_TRI;
    it.corner_a = SLOT_W'(ca);
    it.corner_b = SLOT_W'(cb);
    it.corner_c = SLOT_W'(cc);
    send_item(it);
  endtask

  task automatic send_cmd(input logic [1:0] cmd);
    in_item_t it;
    it = noise_item();
    it.cmd = cmd;
    send_item(it);
  endtask

  // result side: random stall before each beat, then compare with the oldest expectation
  initial begin
    int        stall;
    out_item_t want;
    out_item_t got;
    out_ch.ready = 1'b0;
    stall = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.ready && out_ch.valid) begin
        got = out_ch.data;
        if (pending_ratios.size() == 0) begin
          report("unexpected result beat", got.aspect_ratio, '0);
        end else begin
          want = pending_ratios.pop_front();
          triangles_checked++;
          if (want.degenerate) degenerate_seen++;
          else if (want.aspect_ratio == '1) saturated_seen++;
          if (got.aspect_ratio !== want.aspect_ratio)
            report("aspect_ratio", got.aspect_ratio, want.aspect_ratio);
          if (got.degenerate !== want.degenerate)
            report("degenerate", got.degenerate, want.degenerate);
          if (got.min_ratio !== want.min_ratio)
            report("min_ratio", got.min_ratio, want.min_ratio);
          if (got.max_ratio !== want.max_ratio)
            report("max_ratio", got.max_ratio, want.max_ratio);
          if (got.ratio_sum !== want.ratio_sum)
            report("ratio_sum", got.ratio_sum, want.ratio_sum);
          if (got.triangle_count !== want.triangle_count)
            report("triangle_count", got.triangle_count, want.triangle_count);
        end
        stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (stall > 0) out_ch.ready <= 1'b0;
      end else if (!out_ch.ready && rst_n) begin
        if (stall == 0) out_ch.ready <= 1'b1;
        else stall--;
      end
    end
  end

  // extremes of coordinates and slots, every command, each special case
  task automatic test_directed();
    write_vertex(0, 32'h0, 32'h0, 32'h0);
    write_vertex(DEPTH - 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_vertex(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    write_vertex(12'hAAA, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    write_vertex(12'h555, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    // widest spread: collinear diagonal, then a real triangle at the corners
    send_triangle(0, DEPTH - 1, 1);
    send_triangle(DEPTH - 1, 12'hAAA, 12'h555);
    // repeated corner is degenerate
    send_triangle(0, 0, 0);
    // equilateral triangle between the three unit points on the axes
    write_vertex(2, 32'h0001_0000, 32'h0, 32'h0);
    write_vertex(3, 32'h0, 32'h0001_0000, 32'h0);
    write_vertex(4, 32'h0, 32'h0, 32'h0001_0000);
    send_triangle(2, 3, 4);
    // very flat but not degenerate: quotient beyond 32 bits
    write_vertex(5, 32'h0, 32'h0, 32'h0);
    write_vertex(6, 32'h4000_0000, 32'h0, 32'h0);
    write_vertex(7, 32'h2000_0000, 32'h0010_0000, 32'h0);
    send_triangle(5, 6, 7);
    send_cmd(CMD_UNUSED);
    send_cmd(CMD_CLEAR);
    send_triangle(4, 3, 2);
    send_triangle(12'h555, 12'hAAA, 1);
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_CLEAR);
    send_triangle(7, 5, 6);
  endtask

  function automatic logic [31:0] random_coord(input int scale);
    case (scale)
      0: return 32'($signed($urandom_range(0, 16)) - 8);
      1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // random meshes: writes mostly into a small pool, triangles over written slots, some noise
  task automatic test_random_mesh(input int n_items);
    int pick;
    int scale;
    int slot;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 99);
      scale = $urandom_range(0, 2);
      if (pick < 32) begin
        slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH - 1)
                                           : $urandom_range(0, 23);
        write_vertex(slot, random_coord(scale), random_coord(scale), random_coord(scale));
      end else if (pick < 92) begin
        send_triangle(written_slots[$urandom_range(0, written_slots.size() - 1)],
                      written_slots[$urandom_range(0, written_slots.size() - 1)],
                      written_slots[$urandom_range(0, written_slots.size() - 1)]);
      end else if (pick < 96) begin
        send_cmd(CMD_CLEAR);
      end else begin
        send_cmd(CMD_UNUSED);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    error_count       = 0;
    beats_sent        = 0;
    triangles_checked = 0;
    degenerate_seen   = 0;
    saturated_seen    = 0;
    no_idle           = 1'b0;
    stat_min          = '1;
    stat_max          = '0;
    stat_sum          = '0;
    stat_count        = '0;
    for (int i = 0; i < DEPTH; i++) slot_written[i] = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mesh(700);

    in_ch.valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d beats, %0d triangles checked (%0d degenerate, %0d saturated)",
             beats_sent, triangles_checked, degenerate_seen, saturated_seen);
    if (error_count == 0) begin
      $display("triangle_aspect_ratio_stats_tb: clean");
    end else begin
      $display("triangle_aspect_ratio_stats_tb: errors");
    end
    $finish;
  end

endmodule

/* triangle_aspect_ratio_stats.f */
hw/rtl/tars_pkg.sv
hw/rtl/tars_in_if.sv
hw/rtl/tars_out_if.sv
hw/rtl/tars_vstore.sv
hw/rtl/tars_mul.sv
hw/rtl/tars_root.sv
hw/rtl/tars_div.sv
hw/rtl/triangle_aspect_ratio_stats.sv
bench/triangle_aspect_ratio_stats_tb.sv
